// File: hdl/vtgd_pkg.sv
// ----------------------------------------------------------------------------
// Vector terminal graph decoder package
// Shared types, command codes, control bytes and the Y limit helper.
// ----------------------------------------------------------------------------
package vtgd_pkg;

  // Command codes on the result stream
  typedef enum logic [3:0] {
    CMD_NONE      = 4'd0,
    CMD_MOVE      = 4'd1,
    CMD_DRAW      = 4'd2,
    CMD_POINT     = 4'd3,
    CMD_EXIT      = 4'd4,
    CMD_EXIT_CR   = 4'd5,
    CMD_ALPHA_POS = 4'd6,
    CMD_LF        = 4'd7,
    CMD_BELL      = 4'd8,
    CMD_CLEAR     = 4'd9,
    CMD_STATUS    = 4'd10,
    CMD_CROSSHAIR = 4'd11
  } cmd_e;

  // Host control bytes, matched on all 8 bits
  localparam logic [7:0] CH_ENQ = 8'h05;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SUB = 8'h1A;
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_GS  = 8'h1D;
  localparam logic [7:0] CH_US  = 8'h1F;

  localparam logic [9:0] Y_TOP       = 10'd764;
  localparam logic [6:0] FONT_H_RST  = 7'd16;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic       graph_active;
    logic       pen_lifted;
    logic       vector_shown;
    logic       escape_pending;
    logic [7:0] prev_byte;
    logic [4:0] hi_x;
    logic [4:0] hi_y;
    logic [4:0] lo_y;
    logic [9:0] cur_x;
    logic [9:0] cur_y;
  } state_t;

  // One result item
  typedef struct packed {
    cmd_e       cmd;
    logic [9:0] pos_x;
    logic [9:0] pos_y;
    logic       pass;
  } result_t;

  // Top of the usable Y range for a given font height (never negative)
  function automatic logic [9:0] top_limit(input logic [6:0] font_h);
    top_limit = Y_TOP - {3'b000, font_h};
  endfunction

endpackage

// File: hdl/vtgd_step.sv
// ----------------------------------------------------------------------------
// Vector terminal graph decoder step
// Combinational next state and result for one host byte.
// ----------------------------------------------------------------------------
module vtgd_step (
  input  vtgd_pkg::state_t  st_i,
  input  logic [7:0]        byte_i,
  input  logic [6:0]        font_h_i,
  output vtgd_pkg::state_t  st_o,
  output vtgd_pkg::result_t res_o
);
  import vtgd_pkg::*;

  state_t     nxt;
  cmd_e       cmd;
  logic       pass;
  logic [6:0] c7;
  logic [9:0] lim;
  logic [9:0] nx;
  logic [9:0] ny;
  logic       same;

  assign c7   = byte_i[6:0];
  assign lim  = top_limit(font_h_i);
  assign nx   = {st_i.hi_x, c7[4:0]};
  assign ny   = {st_i.hi_y, st_i.lo_y};
  assign same = (nx == st_i.cur_x) && (ny == st_i.cur_y);

  always_comb begin
    nxt  = st_i;
    cmd  = CMD_NONE;
    pass = 1'b0;
    if (!st_i.graph_active) begin
      if (byte_i == CH_GS) begin
        nxt.graph_active   = 1'b1;
        nxt.pen_lifted     = 1'b1;
        nxt.vector_shown   = 1'b0;
        nxt.escape_pending = 1'b0;
        nxt.prev_byte      = CH_GS;
      end else begin
        pass = 1'b1;
      end
    end else if (st_i.escape_pending) begin
      // byte after ESC: prev_byte stays ESC
      nxt.escape_pending = 1'b0;
      case (byte_i)
        CH_FF: begin
          cmd              = CMD_CLEAR;
          nxt.graph_active = 1'b0;
          nxt.cur_x        = '0;
          nxt.cur_y        = lim;
        end
        CH_ENQ: begin
          cmd = CMD_STATUS;
        end
        CH_SUB: begin
          cmd              = CMD_CROSSHAIR;
          nxt.graph_active = 1'b0;
        end
        default: begin
          cmd = CMD_NONE;
        end
      endcase
    end else begin
      nxt.prev_byte = byte_i;
      case (byte_i)
        CH_GS:  nxt.pen_lifted = 1'b1;
        CH_CR: begin
          cmd              = st_i.vector_shown ? CMD_EXIT_CR : CMD_EXIT;
          nxt.graph_active = 1'b0;
        end
        CH_US: begin
          cmd              = CMD_ALPHA_POS;
          nxt.graph_active = 1'b0;
        end
        CH_LF:  cmd = CMD_LF;
        CH_BEL: cmd = CMD_BELL;
        CH_ESC: nxt.escape_pending = 1'b1;
        default: begin
          case (c7[6:5])
            2'b10: begin
              // low X completes the coordinate
              nxt.vector_shown = 1'b1;
              nxt.cur_x        = nx;
              nxt.cur_y        = ny;
              if (st_i.pen_lifted) begin
                nxt.pen_lifted = 1'b0;
                cmd            = CMD_MOVE;
              end else begin
                cmd = same ? CMD_POINT : CMD_DRAW;
              end
            end
            2'b11: nxt.lo_y = c7[4:0];
            2'b01: begin
              // high byte is X only straight after a low Y byte
              if (st_i.prev_byte[7:5] == 3'b011) begin
                nxt.hi_x = c7[4:0];
              end else begin
                nxt.hi_y = c7[4:0];
              end
            end
            default: cmd = CMD_NONE;
          endcase
        end
      endcase
    end
  end

  assign st_o        = nxt;
  assign res_o.cmd   = cmd;
  assign res_o.pos_x = nxt.cur_x;
  assign res_o.pos_y = ((cmd == CMD_ALPHA_POS) && (nxt.cur_y > lim)) ? lim : nxt.cur_y;
  assign res_o.pass  = pass;

endmodule

// File: hdl/vector_terminal_graph_decoder_top.sv
// ----------------------------------------------------------------------------
// Vector terminal graph decoder, top level
// Decodes a graph-mode host byte stream into one command item per byte.
// ----------------------------------------------------------------------------
// One host byte in gives exactly one command item out. The block takes a byte
// every cycle while the output is not stalled: each byte lands in an input
// register, the decoder step works it out combinationally against the held state
// and the result sits in an output register, so the sustained rate is one item
// per clock, limited only by downstream backpressure. tready on the input side
// drops only when both registers hold items and the output is stalled.
// font_height is written through cfg_we_i/cfg_wdata_i and must only change
// while the block is empty; it resets to 16.
module vector_terminal_graph_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: font_height
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  // host byte stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] host_byte
  // command stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // [3:0] command, [13:4] pos_x, [23:14] pos_y
  output logic        m_tuser_o    // [0] pass_through
);
  import vtgd_pkg::*;

  // configuration register
  logic [6:0] font_q;

  // input stage
  logic       in_vld_q;
  logic [7:0] in_byte_q;

  // decoder state
  state_t     st_q;
  state_t     st_d;
  result_t    res;

  // output stage
  logic       out_vld_q;
  result_t    out_q;

  logic       out_free;
  logic       step_en;

  assign out_free   = !out_vld_q || m_tready_i;
  assign step_en    = in_vld_q && out_free;
  assign s_tready_o = !in_vld_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      font_q <= FONT_H_RST;
    end else if (cfg_we_i) begin
      font_q <= cfg_wdata_i;
    end
  end

  // input register: refills whenever its item moves on or it is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_tready_o) begin
      in_vld_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      in_byte_q <= s_tdata_i;
    end
  end

  vtgd_step u_step (
    .st_i     (st_q),
    .byte_i   (in_byte_q),
    .font_h_i (font_q),
    .st_o     (st_d),
    .res_o    (res)
  );

  // state only advances when the result has a place to go
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.graph_active   <= 1'b0;
      st_q.pen_lifted     <= 1'b1;
      st_q.vector_shown   <= 1'b0;
      st_q.escape_pending <= 1'b0;
      st_q.prev_byte      <= '0;
      st_q.hi_x           <= '0;
      st_q.hi_y           <= '0;
      st_q.lo_y           <= '0;
      st_q.cur_x          <= '0;
      st_q.cur_y          <= '0;
    end else if (step_en) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {out_q.pos_y, out_q.pos_x, out_q.cmd};
  assign m_tuser_o  = out_q.pass;

`ifndef SYNTHESIS
  // an escape can only be pending inside graph mode
  a_esc_in_graph : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.escape_pending |-> st_q.graph_active)
    else $error("escape pending outside graph mode");

  // pass-through bytes never carry a command
  a_pass_no_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o) |-> (m_tdata_o[3:0] == CMD_NONE))
    else $error("pass-through item with a command");

  // a move puts the pen down and marks a vector as shown
  a_move_pen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && (res.cmd == CMD_MOVE)) |=> (st_q.vector_shown && !st_q.pen_lifted))
    else $error("move did not lower the pen");
`endif

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Graph decoder testbench
// Streams host bytes through the decoder under random handshake gaps and
// compares every command item against a cycle-free prediction of the decoder.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vtgd_pkg::*;

  // Cycle ceiling for the whole run. The slowest run is about 2100 items under
  // random handshake gaps, plus the long output hold.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  // Input register plus output register, with a little margin
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned PHASE_ITEMS  = 330;
  localparam int unsigned HOLD_CYCLES  = 300;

  // --------------------------------------------------------------------------
  // Prediction and checking of the command stream
  // --------------------------------------------------------------------------
  class graph_cmd_scoreboard;
    logic [6:0]  font_h;
    bit          graph_on;
    bit          pen_up;
    bit          vec_seen;
    bit          esc_wait;
    logic [7:0]  last_byte;
    logic [4:0]  hx;
    logic [4:0]  hy;
    logic [4:0]  ly;
    logic [9:0]  cx;
    logic [9:0]  cy;
    result_t     pending_cmds[$];
    int unsigned mismatches;
    int unsigned bytes_seen;
    int unsigned cmd_hits[16];
    int unsigned passed_on;

    function new();
      font_h    = 7'd16;
      graph_on  = 1'b0;
      pen_up    = 1'b1;
      vec_seen  = 1'b0;
      esc_wait  = 1'b0;
      last_byte = 8'h00;
      hx        = '0;
      hy        = '0;
      ly        = '0;
      cx        = '0;
      cy        = '0;
    endfunction

    function void set_font_height(logic [6:0] fh);
      font_h = fh;
    endfunction

    function int unsigned backlog();
      return pending_cmds.size();
    endfunction

    function logic [9:0] y_ceiling();
      return Y_TOP - {3'b000, font_h};
    endfunction

    // Coordinate byte: low-Y, high-X/high-Y latch, or low-X which lands the beam
    function cmd_e take_coord(logic [7:0] b, logic [7:0] prior);
      logic [6:0] c;
      logic [9:0] nx;
      logic [9:0] ny;
      bit         same;
      c = b[6:0];
      if (c < 7'd32) return CMD_NONE;
      if (c >= 7'd64 && c <= 7'd95) begin
        nx       = {hx, c[4:0]};
        ny       = {hy, ly};
        same     = (nx == cx) && (ny == cy);
        vec_seen = 1'b1;
        cx       = nx;
        cy       = ny;
        if (pen_up) begin
          pen_up = 1'b0;
          return CMD_MOVE;
        end
        return same ? CMD_POINT : CMD_DRAW;
      end
      if (c >= 7'd96) ly = c[4:0];
      else if (prior >= 8'd96 && prior <= 8'd127) hx = c[4:0];
      else hy = c[4:0];
      return CMD_NONE;
    endfunction

    // One accepted host byte gives exactly one expected command item
    function void predict_byte(logic [7:0] b);
      cmd_e       cmd;
      logic       pass;
      logic [7:0] prior;
      logic [9:0] oy;
      result_t    r;
      cmd  = CMD_NONE;
      pass = 1'b0;
      bytes_seen++;
      if (!graph_on) begin
        if (b == CH_GS) begin
          graph_on  = 1'b1;
          pen_up    = 1'b1;
          vec_seen  = 1'b0;
          esc_wait  = 1'b0;
          last_byte = CH_GS;
        end else begin
          pass = 1'b1;
        end
      end else if (esc_wait) begin
        // byte after ESC is consumed here and never becomes last_byte
        esc_wait = 1'b0;
        case (b)
          CH_FF: begin
            cmd      = CMD_CLEAR;
            graph_on = 1'b0;
            cx       = '0;
            cy       = y_ceiling();
          end
          CH_ENQ: cmd = CMD_STATUS;
          CH_SUB: begin
            cmd      = CMD_CROSSHAIR;
            graph_on = 1'b0;
          end
          default: ;
        endcase
      end else begin
        prior     = last_byte;
        last_byte = b;
        case (b)
          CH_GS:  pen_up = 1'b1;
          CH_CR: begin
            cmd      = vec_seen ? CMD_EXIT_CR : CMD_EXIT;
            graph_on = 1'b0;
          end
          CH_US: begin
            cmd      = CMD_ALPHA_POS;
            graph_on = 1'b0;
          end
          CH_LF:  cmd = CMD_LF;
          CH_BEL: cmd = CMD_BELL;
          CH_ESC: esc_wait = 1'b1;
          default: cmd = take_coord(b, prior);
        endcase
      end
      oy = cy;
      if (cmd == CMD_ALPHA_POS && oy > y_ceiling()) oy = y_ceiling();
      r.cmd   = cmd;
      r.pos_x = cx;
      r.pos_y = oy;
      r.pass  = pass;
      pending_cmds.push_back(r);
    endfunction

    function void check_command(logic [23:0] data, logic user);
      result_t r;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected item, nothing pending: tdata %h tuser %b",
                 $time, data, user);
        mismatches++;
        return;
      end
      r = pending_cmds.pop_front();
      cmd_hits[r.cmd]++;
      if (r.pass) passed_on++;
      if (data[3:0] !== r.cmd) begin
        $display("%0t: command expected %0d got %0d", $time, r.cmd, data[3:0]);
        mismatches++;
      end
      if (data[13:4] !== r.pos_x) begin
        $display("%0t: pos_x expected %0d got %0d", $time, r.pos_x, data[13:4]);
        mismatches++;
      end
      if (data[23:14] !== r.pos_y) begin
        $display("%0t: pos_y expected %0d got %0d", $time, r.pos_y, data[23:14]);
        mismatches++;
      end
      if (user !== r.pass) begin
        $display("%0t: pass_through expected %b got %b", $time, r.pass, user);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and its inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [6:0]  cfg_wdata_i = 7'd0;
  logic        s_tvalid_i  = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i   = 8'h00;
  logic        m_tvalid_o;
  logic        m_tready_i  = 1'b0;
  logic [23:0] m_tdata_o;
  logic        m_tuser_o;

  vector_terminal_graph_decoder_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  graph_cmd_scoreboard sb = new();

  // Host bytes waiting to be offered
  logic [7:0]  host_q[$];
  // Per-phase ceiling on the random gap of each side; 0 means no idling
  int unsigned src_max_gap = 8;
  int unsigned dst_max_gap = 8;
  // Set by the main flow to ask the command side for one long hold
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned phases_run = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Command side: random stalls, one long hold on request. Outputs are read
  // just after the edge, so they are the values the edge itself saw.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = HOLD_CYCLES;
      end else begin
        gap = $urandom_range(0, dst_max_gap);
      end
      if (gap > 0) begin
        m_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
      sb.check_command(m_tdata_o, m_tuser_o);
    end
  end

  // --------------------------------------------------------------------------
  // Host side
  // --------------------------------------------------------------------------
  // tvalid is only dropped when a gap follows, so back-to-back items never
  // see a low and a high scheduled in the same step.
  task automatic send_host_bytes();
    int unsigned gap;
    logic [7:0]  b;
    while (host_q.size() != 0) begin
      b   = host_q.pop_front();
      gap = $urandom_range(0, src_max_gap);
      if (gap > 0) begin
        s_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_tvalid_i <= 1'b1;
      s_tdata_i  <= b;
      do @(posedge clk_i); while (!s_tready_o);
      sb.predict_byte(b);
    end
    s_tvalid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.backlog() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // font_height only moves while the block is empty
  task automatic write_font_height(input logic [6:0] fh);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fh;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_font_height(fh);
  endtask

  // Coordinate byte of a given class (0x20 high, 0x40 low-X, 0x60 low-Y) with
  // random payload; now and then bit 7 is set, which only the control match
  // and the previous-byte test notice.
  function automatic logic [7:0] coord_rnd(input logic [7:0] base);
    logic [7:0] b;
    b = base | 8'($urandom_range(0, 31));
    if ($urandom_range(0, 7) == 0) b[7] = 1'b1;
    return b;
  endfunction

  // One graph-mode session: enter, mostly coordinate groups mixed with
  // controls and noise, then one of the ways out (or none at all).
  task automatic add_session();
    int unsigned steps;
    logic [7:0]  lox;
    repeat ($urandom_range(0, 2)) host_q.push_back(8'($urandom_range(0, 255)));
    host_q.push_back(CH_GS);
    steps = $urandom_range(1, 10);
    repeat (steps) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 1)) host_q.push_back(coord_rnd(8'h20));
          if ($urandom_range(0, 1)) host_q.push_back(coord_rnd(8'h60));
          if ($urandom_range(0, 1)) host_q.push_back(coord_rnd(8'h20));
          lox = coord_rnd(8'h40);
          host_q.push_back(lox);
          // repeating low-X keeps the beam still: point
          if ($urandom_range(0, 2) == 0) host_q.push_back(lox);
        end
        6: begin
          case ($urandom_range(0, 2))
            0: host_q.push_back(CH_BEL);
            1: host_q.push_back(CH_LF);
            default: host_q.push_back(CH_GS);
          endcase
        end
        7: begin
          host_q.push_back(CH_ESC);
          case ($urandom_range(0, 3))
            0: host_q.push_back(CH_FF);
            1: host_q.push_back(CH_ENQ);
            2: host_q.push_back(CH_SUB);
            default: host_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
        8: host_q.push_back(8'($urandom_range(0, 31)));
        default: host_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    case ($urandom_range(0, 4))
      0: host_q.push_back(CH_CR);
      1: host_q.push_back(CH_US);
      2: begin
        host_q.push_back(CH_ESC);
        host_q.push_back(CH_FF);
      end
      3: begin
        host_q.push_back(CH_ESC);
        host_q.push_back(CH_SUB);
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main flow
  // --------------------------------------------------------------------------
  initial begin
    logic [6:0]  font_list[6];
    int unsigned src_list[6];
    int unsigned dst_list[6];

    // Font heights: range ends, the 7-bit extremes, one random, then reset value
    font_list = '{7'd1, 7'd127, 7'd0, 7'd64, 7'd16, 7'd16};
    font_list[4] = 7'($urandom_range(1, 64));
    src_list  = '{8, 0, 8, 0, 8, 3};
    dst_list  = '{8, 8, 0, 0, 8, 3};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walk at the reset font height
    host_q = '{
      // enter, full coordinate at the top corner: move, then still: point
      CH_GS, 8'h3F, 8'h7F, 8'h3F, 8'h5F, 8'h5F,
      // low-X 0 with pen down: draw; bell, line feed, status, unknown escape
      8'h40, CH_BEL, CH_LF, CH_ESC, CH_ENQ, CH_ESC, 8'h41,
      // US with Y above the ceiling: clamped alpha position; alpha byte
      CH_US, 8'h41,
      // CR with nothing drawn
      CH_GS, CH_CR,
      // bit 7 set bytes, null ignored, CR after a vector
      CH_GS, 8'hA0, 8'hC0, 8'h00, CH_CR,
      // clear and crosshair, then top-bit alpha byte
      CH_GS, CH_ESC, CH_FF, CH_GS, CH_ESC, CH_SUB, 8'hFF
    };
    send_host_bytes();

    foreach (font_list[p]) begin
      wait_idle();
      write_font_height(font_list[p]);
      src_max_gap = src_list[p];
      dst_max_gap = dst_list[p];
      // second phase: command side holds off while the host keeps pushing
      if (p == 1) hold_req = 1'b1;
      while (host_q.size() < PHASE_ITEMS) add_session();
      send_host_bytes();
      phases_run++;
    end

    wait_idle();
    $display("Covered %0d host bytes over %0d font heights; %0d passed through.",
             sb.bytes_seen, phases_run, sb.passed_on);
    $display("Moves %0d, draws %0d, points %0d, exits %0d/%0d, alpha pos %0d, clears %0d.",
             sb.cmd_hits[CMD_MOVE], sb.cmd_hits[CMD_DRAW], sb.cmd_hits[CMD_POINT],
             sb.cmd_hits[CMD_EXIT], sb.cmd_hits[CMD_EXIT_CR],
             sb.cmd_hits[CMD_ALPHA_POS], sb.cmd_hits[CMD_CLEAR]);
    if (sb.mismatches == 0 && sb.backlog() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
